// ===== design/epf_pkg.sv =====
// ----------------------------------------------------------------------------
// epf_pkg
// widths, header constants and codes shared by the port filter files
// ----------------------------------------------------------------------------
package epf_pkg;

  localparam int unsigned FRAME_LEN_MAX_DEF = 16383;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PROTO_W  = 8;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned TOTLEN_W = 16;
  localparam int unsigned PKTCNT_W = 32;
  localparam int unsigned BYTECNT_W = 48;
  localparam int unsigned ETYPE_W  = 16;
  localparam int unsigned IHL_W    = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  // ethernet and ipv4 header layout
  localparam int unsigned ETH_HDR     = 14;
  localparam int unsigned IP_MIN      = 20;
  localparam int unsigned TCP_HDR     = 20;
  localparam int unsigned UDP_HDR     = 8;
  localparam int unsigned L4_PORT_LEN = 4;
  localparam int unsigned OFS_ETYPE_HI = 12;
  localparam int unsigned OFS_ETYPE_LO = 13;
  localparam int unsigned OFS_IHL      = 14;
  localparam int unsigned OFS_TOT_HI   = 16;
  localparam int unsigned OFS_TOT_LO   = 17;
  localparam int unsigned OFS_PROTO    = 23;

  localparam logic [ETYPE_W-1:0] ETYPE_IPV4 = 16'h0800;

  localparam logic [PROTO_W-1:0] PROTO_ICMP = 8'd1;
  localparam logic [PROTO_W-1:0] PROTO_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

  localparam logic [MODE_W-1:0] MODE_ANY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TCP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UDP  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ICMP = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPT    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT_ETH = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_IPV4  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_SHORT_IP  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FILTERED  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_MATCH    = 1'd1;

endpackage

// ===== design/epf_in_if.sv =====
// ----------------------------------------------------------------------------
// epf_in_if
// frame byte channel: one byte and its last-byte flag per request
// ----------------------------------------------------------------------------
interface epf_in_if;
  logic                       valid;
  logic                       ready;
  logic [epf_pkg::BYTE_W-1:0] frame_byte;
  logic                       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// ===== design/epf_out_if.sv =====
// ----------------------------------------------------------------------------
// epf_out_if
// per-frame status channel with header fields and counters
// ----------------------------------------------------------------------------
interface epf_out_if;
  logic                          valid;
  logic                          ready;
  logic [epf_pkg::STATUS_W-1:0]  status;
  logic [epf_pkg::PROTO_W-1:0]   ip_protocol;
  logic [epf_pkg::PORT_W-1:0]    source_port;
  logic [epf_pkg::PORT_W-1:0]    destination_port;
  logic [epf_pkg::TOTLEN_W-1:0]  ip_total_length;
  logic [epf_pkg::PKTCNT_W-1:0]  packet_count;
  logic [epf_pkg::BYTECNT_W-1:0] byte_count;

  modport source (output valid, output status, output ip_protocol, output source_port,
                  output destination_port, output ip_total_length, output packet_count,
                  output byte_count, input ready);
  modport sink   (input valid, input status, input ip_protocol, input source_port,
                  input destination_port, input ip_total_length, input packet_count,
                  input byte_count, output ready);
endinterface

// ===== design/epf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// epf_cfg_if
// register write channel: index and data per request
// ----------------------------------------------------------------------------
interface epf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [epf_pkg::CFG_IDX_W-1:0]  index;
  logic [epf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/ethernet_ipv4_port_filter_top.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_port_filter_top
// ethernet / ipv4 layer-4 header parser with protocol and port filter
//
// in_ch takes one frame byte per request in network order, frame_end on the
// last byte. one byte is taken every cycle while in_ch ready is high; the
// throughput is one byte per clock, set by the single byte-capture stage.
// out_ch gives one status request per frame once the last byte is taken,
// through a frame summary register, then the decision and counter update
// into the output register.
// cfg_ch writes protocol_mode (index 0) and port_match (index 1); it is
// always ready. the user writes it only while no frame is in flight; the
// block does not enforce this. reset (rst_n low, synchronous) clears the
// config, the frame state, the valid flags and the packet and byte counters.
// when out_ch stalls, the output register holds and the summary stage fills;
// in_ch ready drops only when both are full, so no byte or result is lost.
// ----------------------------------------------------------------------------
module ethernet_ipv4_port_filter_top #(
  parameter int unsigned FRAME_LEN_MAX = epf_pkg::FRAME_LEN_MAX_DEF
) (
  input logic         clk,
  input logic         rst_n,
  epf_in_if.sink      in_ch,
  epf_out_if.source   out_ch,
  epf_cfg_if.sink     cfg_ch
);
  import epf_pkg::*;

  localparam int unsigned OFF_W = $clog2(FRAME_LEN_MAX + 1);
  localparam int unsigned L4_W  = 7;
  localparam int unsigned HL_W  = IHL_W + 2;
  localparam logic [OFF_W-1:0] LEN_MAX = OFF_W'(FRAME_LEN_MAX);

  // configuration
  logic [MODE_W-1:0] protocol_mode_r;
  logic [PORT_W-1:0] port_match_r;

  // frame capture state
  logic [OFF_W-1:0]    byte_offset_r, byte_offset_nxt;
  logic [ETYPE_W-1:0]  ether_kind_r, ether_kind_nxt;
  logic [IHL_W-1:0]    header_words_r, header_words_nxt;
  logic [PROTO_W-1:0]  proto_seen_r, proto_seen_nxt;
  logic [TOTLEN_W-1:0] length_seen_r, length_seen_nxt;
  logic [2*PORT_W-1:0] ports_seen_r, ports_seen_nxt;
  logic [OFF_W-1:0]    len_nxt;

  // frame summary stage
  logic                s1_valid_r;
  logic [OFF_W-1:0]    s1_len_r;
  logic [ETYPE_W-1:0]  s1_ether_r;
  logic [IHL_W-1:0]    s1_words_r;
  logic [PROTO_W-1:0]  s1_proto_r;
  logic [TOTLEN_W-1:0] s1_length_r;
  logic [2*PORT_W-1:0] s1_ports_r;

  // counters and output register
  logic [PKTCNT_W-1:0]  frames_accepted_r, frames_nxt;
  logic [BYTECNT_W-1:0] bytes_accepted_r, bytes_nxt;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic [PROTO_W-1:0]   proto_r, proto_nxt;
  logic [PORT_W-1:0]    sport_r, sport_nxt;
  logic [PORT_W-1:0]    dport_r, dport_nxt;
  logic [TOTLEN_W-1:0]  tot_r, tot_nxt;

  logic advance, in_take;

  assign advance    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_take    = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  // byte capture
  logic             in_window;
  logic [IHL_W-1:0] hw;
  logic [L4_W-1:0]  l4;
  logic [OFF_W-1:0] l4_ext;
  logic [BYTE_W-1:0] b;

  always_comb begin
    b      = in_ch.frame_byte;
    in_window = byte_offset_r < LEN_MAX;
    hw     = (byte_offset_r == OFF_W'(OFS_IHL)) ? b[IHL_W-1:0] : header_words_r;
    l4     = L4_W'(ETH_HDR) + {1'b0, hw, 2'b00};
    l4_ext = OFF_W'(l4);

    ether_kind_nxt   = ether_kind_r;
    header_words_nxt = header_words_r;
    proto_seen_nxt   = proto_seen_r;
    length_seen_nxt  = length_seen_r;
    ports_seen_nxt   = ports_seen_r;
    len_nxt          = LEN_MAX;
    if (in_window) begin
      if (byte_offset_r == OFF_W'(OFS_ETYPE_HI)) ether_kind_nxt[15:8] = b;
      if (byte_offset_r == OFF_W'(OFS_ETYPE_LO)) ether_kind_nxt[7:0]  = b;
      if (byte_offset_r == OFF_W'(OFS_IHL))      header_words_nxt     = b[IHL_W-1:0];
      if (byte_offset_r == OFF_W'(OFS_TOT_HI))   length_seen_nxt[15:8] = b;
      if (byte_offset_r == OFF_W'(OFS_TOT_LO))   length_seen_nxt[7:0]  = b;
      if (byte_offset_r == OFF_W'(OFS_PROTO))    proto_seen_nxt       = b;
      if (byte_offset_r >= l4_ext && byte_offset_r < l4_ext + OFF_W'(L4_PORT_LEN)) begin
        ports_seen_nxt = {ports_seen_r[2*PORT_W-BYTE_W-1:0], b};
      end
      len_nxt = byte_offset_r + OFF_W'(1);
    end

    byte_offset_nxt = byte_offset_r;
    if (in_ch.frame_end) begin
      byte_offset_nxt = '0;
    end else if (in_window) begin
      byte_offset_nxt = byte_offset_r + OFF_W'(1);
    end
  end

  // frame decision
  logic [HL_W-1:0]  hl;
  logic [OFF_W:0]   ip_end;
  logic [OFF_W-1:0] rem;
  logic             pass, has_ports;

  always_comb begin
    hl     = {s1_words_r, 2'b00};
    ip_end = (OFF_W+1)'(ETH_HDR) + (OFF_W+1)'(hl);
    rem    = s1_len_r - OFF_W'(ETH_HDR) - OFF_W'(hl);
    status_nxt = ST_ACCEPT;
    proto_nxt  = '0;
    sport_nxt  = '0;
    dport_nxt  = '0;
    tot_nxt    = '0;
    frames_nxt = frames_accepted_r;
    bytes_nxt  = bytes_accepted_r;
    pass       = 1'b1;
    has_ports  = 1'b0;
    if (s1_len_r < OFF_W'(ETH_HDR)) begin
      status_nxt = ST_SHORT_ETH;
    end else if (s1_ether_r != ETYPE_IPV4) begin
      status_nxt = ST_NOT_IPV4;
    end else if (s1_len_r < OFF_W'(ETH_HDR + IP_MIN) || {1'b0, s1_len_r} < ip_end) begin
      status_nxt = ST_SHORT_IP;
    end else begin
      proto_nxt = s1_proto_r;
      tot_nxt   = s1_length_r;
      has_ports = (s1_proto_r == PROTO_TCP && rem >= OFF_W'(TCP_HDR)) ||
                  (s1_proto_r == PROTO_UDP && rem >= OFF_W'(UDP_HDR));
      if (has_ports) begin
        sport_nxt = s1_ports_r[2*PORT_W-1:PORT_W];
        dport_nxt = s1_ports_r[PORT_W-1:0];
      end
      case (protocol_mode_r)
        MODE_ANY:  pass = 1'b1;
        MODE_TCP:  pass = (s1_proto_r == PROTO_TCP);
        MODE_UDP:  pass = (s1_proto_r == PROTO_UDP);
        MODE_ICMP: pass = (s1_proto_r == PROTO_ICMP);
        default:   pass = 1'b1;
      endcase
      if (port_match_r != '0 && sport_nxt != port_match_r && dport_nxt != port_match_r) begin
        pass = 1'b0;
      end
      if (pass) begin
        status_nxt = ST_ACCEPT;
        frames_nxt = frames_accepted_r + PKTCNT_W'(1);
        bytes_nxt  = bytes_accepted_r + BYTECNT_W'(s1_length_r);
      end else begin
        status_nxt = ST_FILTERED;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      protocol_mode_r   <= MODE_ANY;
      port_match_r      <= '0;
      byte_offset_r     <= '0;
      ether_kind_r      <= '0;
      header_words_r    <= '0;
      proto_seen_r      <= '0;
      length_seen_r     <= '0;
      ports_seen_r      <= '0;
      s1_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      frames_accepted_r <= '0;
      bytes_accepted_r  <= '0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PROTOCOL_MODE: protocol_mode_r <= cfg_ch.data[MODE_W-1:0];
          REG_PORT_MATCH:    port_match_r    <= cfg_ch.data[PORT_W-1:0];
          default: ;
        endcase
      end
      if (in_take) begin
        byte_offset_r <= byte_offset_nxt;
        if (in_ch.frame_end) begin
          ether_kind_r   <= '0;
          header_words_r <= '0;
          proto_seen_r   <= '0;
          length_seen_r  <= '0;
          ports_seen_r   <= '0;
        end else begin
          ether_kind_r   <= ether_kind_nxt;
          header_words_r <= header_words_nxt;
          proto_seen_r   <= proto_seen_nxt;
          length_seen_r  <= length_seen_nxt;
          ports_seen_r   <= ports_seen_nxt;
        end
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r) begin
          frames_accepted_r <= frames_nxt;
          bytes_accepted_r  <= bytes_nxt;
        end
      end
      if (in_take && in_ch.frame_end) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take && in_ch.frame_end) begin
      s1_len_r    <= len_nxt;
      s1_ether_r  <= ether_kind_nxt;
      s1_words_r  <= header_words_nxt;
      s1_proto_r  <= proto_seen_nxt;
      s1_length_r <= length_seen_nxt;
      s1_ports_r  <= ports_seen_nxt;
    end
    if (advance && s1_valid_r) begin
      status_r <= status_nxt;
      proto_r  <= proto_nxt;
      sport_r  <= sport_nxt;
      dport_r  <= dport_nxt;
      tot_r    <= tot_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = status_r;
  assign out_ch.ip_protocol      = proto_r;
  assign out_ch.source_port      = sport_r;
  assign out_ch.destination_port = dport_r;
  assign out_ch.ip_total_length  = tot_r;
  assign out_ch.packet_count     = frames_accepted_r;
  assign out_ch.byte_count       = bytes_accepted_r;

endmodule

// ===== verif/ethernet_ipv4_port_filter_top_tb.sv =====
// ----------------------------------------------------------------------------
// ethernet_ipv4_port_filter_top_tb
// self-checking bench for the ethernet / ipv4 port filter
//
// frames go in one byte per request: a directed table first, then random
// frames under eight filter settings. a byte-level model of the parser
// predicts each per-frame status request, compared field by field. both
// sides idle at random, save in the last four settings, and the status side
// holds off for one long stretch, so the block fills and stalls byte input.
// ----------------------------------------------------------------------------
module ethernet_ipv4_port_filter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import epf_pkg::*;

  localparam int unsigned FRAME_MAX       = FRAME_LEN_MAX_DEF;
  localparam int unsigned WATCHDOG_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned NUM_ROWS        = 24;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned PHASE_BYTES     = 32;
  localparam int unsigned PHASE_FRAMES    = 1;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam logic [31:0] RANDOM_PORT     = 32'h0001_0000;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_ZERO,
    CHK_NOPORT,
    CHK_FULL
  } chk_kind_t;

  typedef struct packed {
    logic [15:0]         len;
    logic [ETYPE_W-1:0]  etype;
    logic [7:0]          vihl;
    logic [TOTLEN_W-1:0] tot;
    logic [PROTO_W-1:0]  proto;
    logic [PORT_W-1:0]   sp;
    logic [PORT_W-1:0]   dp;
    chk_kind_t           chk;
    logic [STATUS_W-1:0] status;
  } frame_row_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [PROTO_W-1:0]   ip_protocol;
    logic [PORT_W-1:0]    source_port;
    logic [PORT_W-1:0]    destination_port;
    logic [TOTLEN_W-1:0]  ip_total_length;
    logic [PKTCNT_W-1:0]  packet_count;
    logic [BYTECNT_W-1:0] byte_count;
  } frame_status_t;

  localparam frame_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{16'd1,     16'h0800, 8'h45, 16'h0000, 8'h00,      16'h0000, 16'h0000, CHK_ZERO,   ST_SHORT_ETH},
    '{16'd13,    16'h0800, 8'h45, 16'h0000, 8'h00,      16'h0000, 16'h0000, CHK_ZERO,   ST_SHORT_ETH},
    '{16'd14,    16'h0800, 8'h45, 16'h0000, 8'h00,      16'h0000, 16'h0000, CHK_ZERO,   ST_SHORT_IP},
    '{16'd14,    16'h0000, 8'h45, 16'h0000, 8'h00,      16'h0000, 16'h0000, CHK_ZERO,   ST_NOT_IPV4},
    '{16'd60,    16'h86DD, 8'h45, 16'h002E, PROTO_TCP,  16'h0050, 16'h0050, CHK_ZERO,   ST_NOT_IPV4},
    '{16'd60,    16'h0801, 8'h45, 16'h002E, PROTO_UDP,  16'h0035, 16'h0035, CHK_ZERO,   ST_NOT_IPV4},
    '{16'd60,    16'hFF00, 8'h45, 16'h002E, PROTO_TCP,  16'h0001, 16'h0002, CHK_ZERO,   ST_NOT_IPV4},
    '{16'd33,    16'h0800, 8'h45, 16'h0013, PROTO_UDP,  16'h0001, 16'h0002, CHK_ZERO,   ST_SHORT_IP},
    '{16'd34,    16'h0800, 8'h45, 16'h0014, PROTO_ICMP, 16'h0000, 16'h0000, CHK_NOPORT, ST_ACCEPT},
    '{16'd54,    16'h0800, 8'h45, 16'hFFFF, PROTO_TCP,  16'hFFFF, 16'h0000, CHK_FULL,   ST_ACCEPT},
    '{16'd53,    16'h0800, 8'h45, 16'h0027, PROTO_TCP,  16'h1234, 16'h5678, CHK_NOPORT, ST_ACCEPT},
    '{16'd42,    16'h0800, 8'h45, 16'h001C, PROTO_UDP,  16'h0000, 16'hFFFF, CHK_FULL,   ST_ACCEPT},
    '{16'd41,    16'h0800, 8'h45, 16'h001B, PROTO_UDP,  16'h8000, 16'h0001, CHK_NOPORT, ST_ACCEPT},
    '{16'd60,    16'h0800, 8'h4F, 16'h003C, PROTO_TCP,  16'h0001, 16'h0001, CHK_ZERO,   ST_SHORT_IP},
    '{16'd73,    16'h0800, 8'h4F, 16'h003C, PROTO_TCP,  16'h0001, 16'h0001, CHK_ZERO,   ST_SHORT_IP},
    '{16'd74,    16'h0800, 8'h4F, 16'h003C, PROTO_TCP,  16'h0001, 16'h0001, CHK_NOPORT, ST_ACCEPT},
    '{16'd94,    16'h0800, 8'h4F, 16'h0050, PROTO_UDP,  16'hAAAA, 16'h5555, CHK_FULL,   ST_ACCEPT},
    '{16'd60,    16'h0800, 8'h65, 16'h002E, PROTO_UDP,  16'h0035, 16'hC000, CHK_FULL,   ST_ACCEPT},
    '{16'd60,    16'h0800, 8'h44, 16'h002E, PROTO_TCP,  16'h0102, 16'h0304, CHK_MODEL,  ST_ACCEPT},
    '{16'd40,    16'h0800, 8'h40, 16'h0026, PROTO_UDP,  16'h4321, 16'h8765, CHK_MODEL,  ST_ACCEPT},
    '{16'd40,    16'h0800, 8'h42, 16'h0026, PROTO_UDP,  16'h0611, 16'h1106, CHK_MODEL,  ST_ACCEPT},
    '{16'd60,    16'h0800, 8'h45, 16'h002E, 8'h02,      16'h0001, 16'h0002, CHK_NOPORT, ST_ACCEPT},
    '{16'd64,    16'h0800, 8'h45, 16'h0000, 8'hFF,      16'h0001, 16'h0002, CHK_NOPORT, ST_ACCEPT},
    '{16'd64,    16'h0800, 8'h45, 16'h0000, PROTO_TCP,  16'h7FFF, 16'h8000, CHK_FULL,   ST_ACCEPT}
  };

  localparam logic [MODE_W-1:0] PHASE_MODE [NUM_PHASES] = '{
    MODE_ANY, MODE_TCP, MODE_UDP, MODE_ICMP, MODE_ANY, MODE_TCP, MODE_UDP, MODE_ICMP
  };
  localparam logic [31:0] PHASE_PORT [NUM_PHASES] = '{
    32'h0, 32'h0, 32'hFFFF, 32'h0, RANDOM_PORT, RANDOM_PORT, 32'h0001, RANDOM_PORT
  };

  logic clk;
  logic rst_n;

  epf_in_if  in_ch ();
  epf_out_if out_ch ();
  epf_cfg_if cfg_ch ();

  ethernet_ipv4_port_filter_top #(
    .FRAME_LEN_MAX(FRAME_MAX)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // parser state
  int unsigned          frame_pos;
  logic [ETYPE_W-1:0]   eth_kind;
  logic [IHL_W-1:0]     hdr_words;
  logic [PROTO_W-1:0]   ip_proto;
  logic [TOTLEN_W-1:0]  tot_len;
  logic [31:0]          l4_ports;
  logic [PKTCNT_W-1:0]  accepted_frames;
  logic [BYTECNT_W-1:0] accepted_bytes;
  logic [MODE_W-1:0]    cur_mode;
  logic [PORT_W-1:0]    cur_port;

  frame_row_t    frame_checks [$];
  frame_status_t pending [$];
  logic [7:0]    frame_buf [$];

  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned frames_sent;
  int unsigned bytes_sent;
  int unsigned reg_writes;
  int unsigned passed_seen;
  int unsigned dropped_seen;
  logic        steady;
  logic        hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void parse_frame_byte(input logic [7:0] b, input logic last);
    int unsigned pos, len, hw, l4, hl, rem;
    logic in_window, pass;
    frame_status_t r;
    frame_row_t t;
    pos = frame_pos;
    in_window = pos < FRAME_MAX;
    len = FRAME_MAX;
    if (in_window) begin
      hw = (pos == OFS_IHL) ? b[3:0] : hdr_words;
      l4 = ETH_HDR + 4 * hw;
      if (pos == OFS_ETYPE_HI) eth_kind[15:8] = b;
      if (pos == OFS_ETYPE_LO) eth_kind[7:0] = b;
      if (pos == OFS_IHL) hdr_words = b[3:0];
      if (pos == OFS_TOT_HI) tot_len[15:8] = b;
      if (pos == OFS_TOT_LO) tot_len[7:0] = b;
      if (pos == OFS_PROTO) ip_proto = b;
      if (pos >= l4 && pos < l4 + L4_PORT_LEN) l4_ports = {l4_ports[23:0], b};
      len = pos + 1;
    end
    if (!last) begin
      if (in_window) frame_pos = pos + 1;
      return;
    end
    r = '0;
    hl = 4 * hdr_words;
    if (len < ETH_HDR) begin
      r.status = ST_SHORT_ETH;
    end else if (eth_kind != ETYPE_IPV4) begin
      r.status = ST_NOT_IPV4;
    end else if (len < ETH_HDR + IP_MIN || len < ETH_HDR + hl) begin
      r.status = ST_SHORT_IP;
    end else begin
      rem = len - ETH_HDR - hl;
      r.ip_protocol = ip_proto;
      r.ip_total_length = tot_len;
      if ((ip_proto == PROTO_TCP && rem >= TCP_HDR) ||
          (ip_proto == PROTO_UDP && rem >= UDP_HDR)) begin
        r.source_port = l4_ports[31:16];
        r.destination_port = l4_ports[15:0];
      end
      pass = 1'b1;
      if (cur_mode == MODE_TCP && ip_proto != PROTO_TCP) pass = 1'b0;
      if (cur_mode == MODE_UDP && ip_proto != PROTO_UDP) pass = 1'b0;
      if (cur_mode == MODE_ICMP && ip_proto != PROTO_ICMP) pass = 1'b0;
      if (cur_port != '0 && r.source_port != cur_port && r.destination_port != cur_port)
        pass = 1'b0;
      if (pass) begin
        r.status = ST_ACCEPT;
        accepted_frames = accepted_frames + 1'b1;
        accepted_bytes = accepted_bytes + BYTECNT_W'(tot_len);
      end else begin
        r.status = ST_FILTERED;
      end
    end
    r.packet_count = accepted_frames;
    r.byte_count = accepted_bytes;
    // table rows with a typed result override the header fields
    if (frame_checks.size() != 0) begin
      t = frame_checks.pop_front();
      if (t.chk != CHK_MODEL) begin
        r.status = t.status;
        r.ip_protocol = (t.chk == CHK_ZERO) ? '0 : t.proto;
        r.ip_total_length = (t.chk == CHK_ZERO) ? '0 : t.tot;
        r.source_port = (t.chk == CHK_FULL) ? t.sp : '0;
        r.destination_port = (t.chk == CHK_FULL) ? t.dp : '0;
      end
    end
    pending.push_back(r);
    frame_pos = 0;
    eth_kind = '0;
    hdr_words = '0;
    ip_proto = '0;
    tot_len = '0;
    l4_ports = '0;
  endfunction

  function automatic void check_status();
    frame_status_t got, want;
    got.status = out_ch.status;
    got.ip_protocol = out_ch.ip_protocol;
    got.source_port = out_ch.source_port;
    got.destination_port = out_ch.destination_port;
    got.ip_total_length = out_ch.ip_total_length;
    got.packet_count = out_ch.packet_count;
    got.byte_count = out_ch.byte_count;
    if (got.status == ST_ACCEPT) passed_seen++;
    else dropped_seen++;
    if (pending.size() == 0) begin
      if (errors < MAX_REPORTS)
        $display("status request with no frame pending: st=%0d proto=%0d", got.status,
                 got.ip_protocol);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.status !== want.status || got.ip_protocol !== want.ip_protocol ||
        got.source_port !== want.source_port ||
        got.destination_port !== want.destination_port ||
        got.ip_total_length !== want.ip_total_length ||
        got.packet_count !== want.packet_count || got.byte_count !== want.byte_count) begin
      if (errors < MAX_REPORTS) begin
        $display("mismatch exp: st=%0d proto=%0d sp=%h dp=%h len=%h pkts=%0d bytes=%0d",
                 want.status, want.ip_protocol, want.source_port, want.destination_port,
                 want.ip_total_length, want.packet_count, want.byte_count);
        $display("         got: st=%0d proto=%0d sp=%h dp=%h len=%h pkts=%0d bytes=%0d",
                 got.status, got.ip_protocol, got.source_port, got.destination_port,
                 got.ip_total_length, got.packet_count, got.byte_count);
      end
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) check_status();
      if (in_ch.valid && in_ch.ready) parse_frame_byte(in_ch.frame_byte, in_ch.frame_end);
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_PROTOCOL_MODE: cur_mode = cfg_ch.data[MODE_W-1:0];
          REG_PORT_MATCH:    cur_port = cfg_ch.data;
          default: ;
        endcase
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles, %0d status requests pending",
               quiet_cycles, pending.size());
      $display("[ethernet_ipv4_port_filter_top] ERROR");
      $finish;
    end
  end

  // status side: random stalls, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(0, 99) >= 29);
      end
    end
  end

  function automatic void put_byte(input int unsigned pos, input logic [7:0] val);
    if (pos < frame_buf.size()) frame_buf[pos] = val;
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return PROTO_TCP;
    if (sel < 7) return PROTO_UDP;
    if (sel < 9) return PROTO_ICMP;
    return PROTO_W'($urandom);
  endfunction

  function automatic logic [PORT_W-1:0] pick_port();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return cur_port;
    if (sel == 4) return '0;
    if (sel == 5) return '1;
    return PORT_W'($urandom);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.frame_end <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_frame(input frame_row_t row);
    int unsigned l4, i;
    frame_buf.delete();
    for (i = 0; i < row.len; i++) frame_buf.push_back(8'($urandom));
    l4 = ETH_HDR + 4 * row.vihl[3:0];
    put_byte(OFS_ETYPE_HI, row.etype[15:8]);
    put_byte(OFS_ETYPE_LO, row.etype[7:0]);
    put_byte(OFS_IHL, row.vihl);
    put_byte(OFS_TOT_HI, row.tot[15:8]);
    put_byte(OFS_TOT_LO, row.tot[7:0]);
    put_byte(OFS_PROTO, row.proto);
    put_byte(l4, row.sp[15:8]);
    put_byte(l4 + 1, row.sp[7:0]);
    put_byte(l4 + 2, row.dp[15:8]);
    put_byte(l4 + 3, row.dp[7:0]);
    frame_checks.push_back(row);
    for (i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
    bytes_sent += row.len;
  endtask

  task automatic next_random_row(output frame_row_t row);
    int unsigned sel, ihl, hdr, base;
    row = '0;
    row.etype = ETYPE_IPV4;
    row.vihl = 8'h45;
    row.tot = TOTLEN_W'($urandom);
    row.proto = pick_proto();
    row.sp = pick_port();
    row.dp = pick_port();
    row.chk = CHK_MODEL;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      // well-formed ipv4 with random content
      ihl = ($urandom_range(0, 99) < 80) ? 5 : $urandom_range(5, 15);
      row.vihl = {($urandom_range(0, 99) < 85) ? 4'h4 : 4'($urandom), 4'(ihl)};
      hdr = (row.proto == PROTO_TCP) ? TCP_HDR : (row.proto == PROTO_UDP) ? UDP_HDR : 0;
      base = ETH_HDR + 4 * ihl;
      if ($urandom_range(0, 99) < 15) row.len = 16'(base + $urandom_range(0, hdr));
      else row.len = 16'(base + hdr + $urandom_range(0, 16));
    end else if (sel < 63) begin
      row.len = 16'($urandom_range(1, ETH_HDR - 1));
    end else if (sel < 73) begin
      row.etype = ETYPE_W'($urandom);
      if (row.etype == ETYPE_IPV4) row.etype[0] = 1'b1;
      row.len = 16'($urandom_range(ETH_HDR, 70));
    end else if (sel < 85) begin
      row.vihl[3:0] = 4'($urandom_range(5, 15));
      row.len = 16'($urandom_range(ETH_HDR, ETH_HDR + 4 * row.vihl[3:0] - 1));
    end else if (sel < 93) begin
      // ihl below the minimum puts the ports inside the ip header
      row.vihl[3:0] = 4'($urandom_range(0, 4));
      row.len = 16'($urandom_range(ETH_HDR, 60));
    end else begin
      row.etype = $urandom_range(0, 1) ? ETYPE_IPV4 : ETYPE_W'($urandom);
      row.vihl = 8'($urandom);
      row.proto = PROTO_W'($urandom);
      row.len = 16'($urandom_range(1, 80));
    end
  endtask

  task automatic drain_frames();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_filter(input logic [MODE_W-1:0] mode, input logic [PORT_W-1:0] port);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_PROTOCOL_MODE;
    cfg_ch.data <= {14'($urandom), mode};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.index <= REG_PORT_MATCH;
    cfg_ch.data <= port;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
    reg_writes += 2;
  endtask

  initial begin
    frame_row_t row;
    int unsigned ph, ph_bytes, ph_frames, r;
    logic [PORT_W-1:0] port;
    frame_pos = 0;
    eth_kind = '0;
    hdr_words = '0;
    ip_proto = '0;
    tot_len = '0;
    l4_ports = '0;
    accepted_frames = '0;
    accepted_bytes = '0;
    cur_mode = MODE_ANY;
    cur_port = '0;
    errors = 0;
    quiet_cycles = 0;
    frames_sent = 0;
    bytes_sent = 0;
    reg_writes = 0;
    passed_seen = 0;
    dropped_seen = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.frame_byte <= '0;
    in_ch.frame_end <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_PROTOCOL_MODE;
    cfg_ch.data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed frames under the reset filter setting, status side held off first
    hold_req = 1'b1;
    for (r = 0; r < NUM_ROWS; r++) send_frame(DIRECTED_ROWS[r]);

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain_frames();
      port = (PHASE_PORT[ph] == RANDOM_PORT) ? PORT_W'($urandom_range(1, 65535))
                                             : PHASE_PORT[ph][PORT_W-1:0];
      write_filter(PHASE_MODE[ph], port);
      steady = (ph >= 4);
      ph_bytes = 0;
      ph_frames = 0;
      while (ph_bytes < PHASE_BYTES || ph_frames < PHASE_FRAMES) begin
        next_random_row(row);
        send_frame(row);
        ph_bytes += row.len;
        ph_frames++;
      end
    end
    steady = 1'b0;
    drain_frames();

    if (pending.size() != 0 || frame_checks.size() != 0) errors++;
    $display("sent %0d frames (%0d bytes) under %0d filter settings, %0d register writes",
             frames_sent, bytes_sent, NUM_PHASES + 1, reg_writes);
    $display("status requests: %0d accepted, %0d rejected or filtered, %0d mismatches",
             passed_seen, dropped_seen, errors);
    if (errors == 0) begin
      $display("[ethernet_ipv4_port_filter_top] OK");
    end else begin
      $display("[ethernet_ipv4_port_filter_top] ERROR");
    end
    $finish;
  end

endmodule
